@@ hdl/bpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_AC1     = 3'd0;
  localparam logic [2:0] REG_AC2     = 3'd1;
  localparam logic [2:0] REG_AC3     = 3'd2;
  localparam logic [2:0] REG_AC4     = 3'd3;
  localparam logic [2:0] REG_AC5_AC6 = 3'd4;
  localparam logic [2:0] REG_B1_B2   = 3'd5;
  localparam logic [2:0] REG_MC_MD   = 3'd6;
  localparam logic [2:0] REG_OSS     = 3'd7;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 40;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // quotient bits, one per divider stage
  localparam int DIV_W = 32;

  localparam logic [31:0] B6_OFS   = 32'd4000;
  localparam logic [31:0] B4_OFS   = 32'd32768;
  localparam logic [31:0] B7_SCALE = 32'd50000;
  localparam logic [31:0] P_C1     = 32'd3038;
  localparam logic [31:0] P_C2     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_C3     = 32'd3791;
  localparam logic [17:0] P_MAX    = 18'h3FFFF;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cfg_t;

  // one reading after the front has shifted the pressure word
  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
  } item_t;

  // context carried down the back pipeline
  typedef struct packed {
    logic [18:0] up;
    logic [31:0] x1;
    logic [31:0] t;
    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] rc;
    logic [31:0] rd;
    logic        err;
    logic        neg;
    logic        shf;
  } ctx_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // low 32 bits of a 32 x 32 product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

endpackage
`default_nettype wire

@@ hdl/bpc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpc_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [1:0]            oss,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [39:0]           in_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
  input  wire                   q_full,
  output logic                  q_push,
  output bpc_pkg::item_t        q_data
);
  import bpc_pkg::*;

  logic        f_vld_r;
  item_t       f_r;
  item_t       f_nxt;
  logic [23:0] raw_p;
  logic [23:0] up_full;

  // pressure word is right-aligned by 8 - oss
  always_comb begin
    raw_p    = in_tdata[39:16];
    up_full  = raw_p >> (4'd8 - {2'b00, oss});
    f_nxt.ut = in_tdata[15:0];
    f_nxt.up = up_full[18:0];
  end

  assign q_push    = f_vld_r && !q_full;
  assign q_data    = f_r;
  assign in_tready = !f_vld_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (in_tready) begin
      f_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      f_r <= f_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/bpc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpc_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  bpc_pkg::item_t        push_data,
  output logic                  full,
  input  wire                   pop,
  output logic                  empty,
  output bpc_pkg::item_t        head
);
  import bpc_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_r;
  logic [QAW-1:0] rd_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count past depth");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |=> cnt_r == (QAW+1)'(QDEPTH)) else $error("full queue changed");
  a_empty_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !do_push |=> empty) else $error("empty queue gained a word");

endmodule
`default_nettype wire

@@ hdl/bpc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpc_div (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   in_vld,
  input  wire  [31:0]           num,
  input  wire  [31:0]           den,
  input  bpc_pkg::ctx_t         in_ctx,
  output logic                  out_vld,
  output logic [31:0]           quo,
  output bpc_pkg::ctx_t         out_ctx
);
  import bpc_pkg::*;

  // restoring divider, one quotient bit per stage
  logic [31:0] rem_r [DIV_W];
  logic [31:0] quo_r [DIV_W];
  logic [31:0] den_r [DIV_W];
  ctx_t        ctx_r [DIV_W];
  logic        vld_r [DIV_W];

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic [31:0] rem_i;
    logic [31:0] quo_i;
    logic [31:0] den_i;
    ctx_t        ctx_i;
    logic        vld_i;
    logic [32:0] tr;
    logic [32:0] diff;

    if (i == 0) begin : g_first
      assign rem_i = '0;
      assign quo_i = num;
      assign den_i = den;
      assign ctx_i = in_ctx;
      assign vld_i = in_vld;
    end else begin : g_next
      assign rem_i = rem_r[i-1];
      assign quo_i = quo_r[i-1];
      assign den_i = den_r[i-1];
      assign ctx_i = ctx_r[i-1];
      assign vld_i = vld_r[i-1];
    end

    // shift in the next dividend bit and try the subtract
    always_comb begin
      tr   = {rem_i, quo_i[31]};
      diff = tr - {1'b0, den_i};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= diff[32] ? tr[31:0] : diff[31:0];
        quo_r[i] <= {quo_i[30:0], ~diff[32]};
        den_r[i] <= den_i;
        ctx_r[i] <= ctx_i;
      end
    end
  end

  assign out_vld = vld_r[DIV_W-1];
  assign quo     = quo_r[DIV_W-1];
  assign out_ctx = ctx_r[DIV_W-1];

endmodule
`default_nettype wire

@@ hdl/bpc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpc_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  bpc_pkg::cfg_t         cfg,
  input  wire                   q_empty,
  input  bpc_pkg::item_t        q_head,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [39:0]           out_tdata,  // temperature_tenths[15:0], pressure_pa[33:16]
  output logic                  out_tuser   // divide_error
);
  import bpc_pkg::*;

  logic en;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic s6_vld_r, s7_vld_r, s8_vld_r, s9_vld_r;
  ctx_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r;
  ctx_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt;
  ctx_t s9_nxt;

  logic        d1_vld, d2_vld;
  logic [31:0] d1_q, d2_q;
  ctx_t        d1_ctx, d2_ctx;

  logic        out_vld_r;
  logic [15:0] temp_r, temp_nxt;
  logic [17:0] pres_r, pres_nxt;
  logic        err_r;

  // whole pipeline moves unless the output word is stuck
  assign en    = !out_vld_r || out_tready;
  assign q_pop = en;

  // stage 1: (ut - ac6) * ac5
  always_comb begin
    s1_nxt    = '0;
    s1_nxt.up = q_head.up;
    s1_nxt.ra = mul32({16'd0, q_head.ut} - {16'd0, cfg.ac6}, {16'd0, cfg.ac5});
  end

  // stage 2: temperature divisor, split signed divide into magnitudes
  always_comb begin
    logic [31:0] x1, dn, nm;
    x1         = asr32(s1_r.ra, 15);
    dn         = x1 + sx16(cfg.md);
    nm         = sx16(cfg.mc) << 11;
    s2_nxt     = s1_r;
    s2_nxt.x1  = x1;
    s2_nxt.err = (dn == '0);
    s2_nxt.neg = nm[31] ^ dn[31];
    s2_nxt.ra  = nm[31] ? (32'd0 - nm) : nm;
    s2_nxt.rb  = dn[31] ? (32'd0 - dn) : dn;
  end

  bpc_div u_div_t (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s2_vld_r),
    .num    (s2_r.ra),
    .den    (s2_r.rb),
    .in_ctx (s2_r),
    .out_vld(d1_vld),
    .quo    (d1_q),
    .out_ctx(d1_ctx)
  );

  // stage 3: b5, temperature, b6 products
  always_comb begin
    logic [31:0] x2, b5, b6;
    x2        = d1_ctx.neg ? (32'd0 - d1_q) : d1_q;
    b5        = d1_ctx.x1 + x2;
    b6        = b5 - B6_OFS;
    s3_nxt    = d1_ctx;
    s3_nxt.t  = asr32(b5 + 32'd8, 4);
    s3_nxt.ra = mul32(b6, b6);
    s3_nxt.rb = mul32(sx16(cfg.ac2), b6);
    s3_nxt.rc = mul32(sx16(cfg.ac3), b6);
  end

  // stage 4: square term times b2 and b1, ac2 and ac3 products shifted
  always_comb begin
    logic [31:0] sq;
    sq        = asr32(s3_r.ra, 12);
    s4_nxt    = s3_r;
    s4_nxt.ra = mul32(sx16(cfg.b2), sq);
    s4_nxt.rb = asr32(s3_r.rb, 11);
    s4_nxt.rc = asr32(s3_r.rc, 13);
    s4_nxt.rd = mul32(sx16(cfg.b1), sq);
  end

  // stage 5: b3 and the b4 sum
  always_comb begin
    logic [31:0] x3, b3w;
    x3        = asr32(s4_r.ra, 11) + s4_r.rb;
    b3w       = ((sx16(cfg.ac1) << 2) + x3) << cfg.oss;
    s5_nxt    = s4_r;
    s5_nxt.ra = asr32(b3w + 32'd2, 2);
    s5_nxt.rb = asr32(s4_r.rc + asr32(s4_r.rd, 16) + 32'd2, 2);
  end

  // stage 6: ac4 product, up - b3
  always_comb begin
    s6_nxt    = s5_r;
    s6_nxt.ra = mul32({16'd0, cfg.ac4}, s5_r.rb + B4_OFS);
    s6_nxt.rb = {13'd0, s5_r.up} - s5_r.ra;
  end

  // stage 7: b4, b7 and the divide operands
  always_comb begin
    logic [31:0] b4, b7;
    b4         = s6_r.ra >> 15;
    b7         = mul32(s6_r.rb, B7_SCALE >> cfg.oss);
    s7_nxt     = s6_r;
    s7_nxt.err = s6_r.err || (b4 == '0);
    s7_nxt.shf = b7[31];
    s7_nxt.ra  = b7[31] ? b7 : (b7 << 1);
    s7_nxt.rb  = b4;
  end

  bpc_div u_div_p (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s7_vld_r),
    .num    (s7_r.ra),
    .den    (s7_r.rb),
    .in_ctx (s7_r),
    .out_vld(d2_vld),
    .quo    (d2_q),
    .out_ctx(d2_ctx)
  );

  // stage 8: p and its correction products
  always_comb begin
    logic [31:0] p, x1;
    p         = d2_ctx.shf ? (d2_q << 1) : d2_q;
    x1        = asr32(p, 8);
    s8_nxt    = d2_ctx;
    s8_nxt.ra = mul32(x1, x1);
    s8_nxt.rb = mul32(P_C2, p);
    s8_nxt.rc = p;
  end

  // stage 9: second product of the square term
  always_comb begin
    s9_nxt    = s8_r;
    s9_nxt.ra = mul32(s8_r.ra, P_C1);
  end

  // final correction and saturation
  always_comb begin
    logic [31:0] p;
    p = s9_r.rc + asr32(asr32(s9_r.ra, 16) + asr32(s9_r.rb, 16) + P_C3, 4);
    if ($signed(s9_r.t) > 32'sd32767) begin
      temp_nxt = 16'h7FFF;
    end else if ($signed(s9_r.t) < -32'sd32768) begin
      temp_nxt = 16'h8000;
    end else begin
      temp_nxt = s9_r.t[15:0];
    end
    if (p[31]) begin
      pres_nxt = '0;
    end else if (p > {14'd0, P_MAX}) begin
      pres_nxt = P_MAX;
    end else begin
      pres_nxt = p[17:0];
    end
    if (s9_r.err) begin
      temp_nxt = '0;
      pres_nxt = '0;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= !q_empty;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= d1_vld;
      s4_vld_r  <= s3_vld_r;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= d2_vld;
      s9_vld_r  <= s8_vld_r;
      out_vld_r <= s9_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      s4_r   <= s4_nxt;
      s5_r   <= s5_nxt;
      s6_r   <= s6_nxt;
      s7_r   <= s7_nxt;
      s8_r   <= s8_nxt;
      s9_r   <= s9_nxt;
      temp_r <= temp_nxt;
      pres_r <= pres_nxt;
      err_r  <= s9_r.err;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, pres_r, temp_r};
  assign out_tuser  = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && err_r |-> temp_r == '0 && pres_r == '0)
    else $error("divide error word carries nonzero fields");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s9_vld_r) && $stable(s2_vld_r))
    else $error("pipeline moved while stalled");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    en && !q_empty |=> s1_vld_r)
    else $error("popped word did not enter stage 1");

endmodule
`default_nettype wire

@@ hdl/barometric_pressure_compensation_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Integer compensation for a barometric sensor: each input word carries a raw
// temperature and a raw 24-bit pressure reading, each output word the
// temperature in 0.1 C and the pressure in Pa (tuser flags a zero divisor, then
// both fields are zero). One word is taken per clock while in_tready is high; a word
// reaches out_tvalid through the input register, the 4-word queue and the back
// pipeline: ten arithmetic stages around the two 32-stage pipelined dividers
// (temperature and pressure). A stalled output word holds the whole back
// pipeline; the queue then fills and in_tready drops.
// Write calibration registers and oversampling only while no word is in flight.
module barometric_pressure_compensation_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bpc_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [bpc_pkg::IN_W-1:0]        in_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [bpc_pkg::OUT_W-1:0]       out_tdata,  // temperature_tenths[15:0], pressure_pa[33:16]
  output logic                            out_tuser   // divide_error
);
  import bpc_pkg::*;

  logic [15:0] ac1_r, ac2_r, ac3_r, ac4_r;
  logic [31:0] ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;
  cfg_t        cfg;

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_head;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r  <= '0;
      ac2_r  <= '0;
      ac3_r  <= '0;
      ac4_r  <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
      oss_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AC1:     ac1_r  <= cfg_data[15:0];
        REG_AC2:     ac2_r  <= cfg_data[15:0];
        REG_AC3:     ac3_r  <= cfg_data[15:0];
        REG_AC4:     ac4_r  <= cfg_data[15:0];
        REG_AC5_AC6: ac56_r <= cfg_data;
        REG_B1_B2:   b12_r  <= cfg_data;
        REG_MC_MD:   mcmd_r <= cfg_data;
        REG_OSS:     oss_r  <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    cfg.ac1 = ac1_r;
    cfg.ac2 = ac2_r;
    cfg.ac3 = ac3_r;
    cfg.ac4 = ac4_r;
    cfg.ac5 = ac56_r[31:16];
    cfg.ac6 = ac56_r[15:0];
    cfg.b1  = b12_r[31:16];
    cfg.b2  = b12_r[15:0];
    cfg.mc  = mcmd_r[31:16];
    cfg.md  = mcmd_r[15:0];
    cfg.oss = oss_r;
  end

  bpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .oss      (oss_r),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  bpc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  bpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import bpc_pkg::*;

  // calibration setups used by the phases of the run
  typedef enum int {CAL_RESET, CAL_TYPICAL, CAL_NUDGED, CAL_ALL_HI, CAL_ALL_LO,
                    CAL_NO_B4, CAL_RANDOM} cal_kind_e;

  typedef struct packed {
    logic [15:0] temp;
    logic [17:0] press;
    logic        err;
  } reading_t;

  // one row of the directed table; typed rows carry their result
  typedef struct {
    cal_kind_e   kind;
    logic [1:0]  oss;
    logic [15:0] ut;
    logic [23:0] up;
    bit          typed;
    reading_t    res;
  } row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  barometric_pressure_compensation_core dut (.*);

  always #6 clk = ~clk;

  // shadow copy of the calibration registers
  logic [31:0] cal_reg [8];
  reading_t    readings_due[$];
  bit          typed_flag[$];
  reading_t    typed_res[$];
  int          mismatches = 0;
  int          words_in = 0, words_out = 0, div_errors = 0;
  bit          calm = 0;
  int          stall_left = 0;

  function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
    logic [31:0] r;
    r = $signed(v) >>> n;
    return r;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // integer compensation of one reading with the shadow calibration
  function automatic reading_t compensate(input logic [15:0] ut_w, input logic [23:0] up_w);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, d, acc;
    logic [1:0]  oss;
    longint      q;
    int          ts, ps;
    reading_t    r;
    r = '{temp: '0, press: '0, err: 1'b1};
    oss = cal_reg[REG_OSS][1:0];
    ac1 = ext16(cal_reg[REG_AC1][15:0]);
    ac2 = ext16(cal_reg[REG_AC2][15:0]);
    ac3 = ext16(cal_reg[REG_AC3][15:0]);
    ac4 = {16'd0, cal_reg[REG_AC4][15:0]};
    ac5 = {16'd0, cal_reg[REG_AC5_AC6][31:16]};
    ac6 = {16'd0, cal_reg[REG_AC5_AC6][15:0]};
    b1 = ext16(cal_reg[REG_B1_B2][31:16]);
    b2 = ext16(cal_reg[REG_B1_B2][15:0]);
    mc = ext16(cal_reg[REG_MC_MD][31:16]);
    md = ext16(cal_reg[REG_MC_MD][15:0]);
    ut = {16'd0, ut_w};
    up = {8'd0, up_w} >> (8 - oss);

    // temperature
    acc = (ut - ac6) * ac5;
    x1 = shr_s(acc, 15);
    d = x1 + md;
    if (d == 0) return r;
    acc = mc * 32'd2048;
    q = longint'($signed(acc)) / longint'($signed(d));
    x2 = q[31:0];
    b5 = x1 + x2;
    t = shr_s(b5 + 32'd8, 4);

    // pressure scale terms
    b6 = b5 - 32'd4000;
    acc = b6 * b6;
    sq = shr_s(acc, 12);
    acc = b2 * sq;
    x1 = shr_s(acc, 11);
    acc = ac2 * b6;
    x2 = shr_s(acc, 11);
    x3 = x1 + x2;
    acc = ((ac1 * 32'd4 + x3) << oss) + 32'd2;
    b3 = shr_s(acc, 2);
    acc = ac3 * b6;
    x1 = shr_s(acc, 13);
    acc = b1 * sq;
    x2 = shr_s(acc, 16);
    x3 = shr_s(x1 + x2 + 32'd2, 2);
    acc = ac4 * (x3 + 32'd32768);
    b4 = acc >> 15;
    if (b4 == 0) return r;

    // main division, then the final correction
    b7 = (up - b3) * (32'd50000 >> oss);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shr_s(p, 8);
    acc = x1 * x1 * 32'd3038;
    x1 = shr_s(acc, 16);
    acc = 32'hFFFF_E343 * p;
    x2 = shr_s(acc, 16);
    p = p + shr_s(x1 + x2 + 32'd3791, 4);

    ts = $signed(t);
    if (ts > 32767) ts = 32767;
    if (ts < -32768) ts = -32768;
    ps = $signed(p);
    if (ps < 0) ps = 0;
    if (ps > 262143) ps = 262143;
    r.temp = ts[15:0];
    r.press = ps[17:0];
    r.err = 1'b0;
    return r;
  endfunction

  // accepted words: queue the expected reading; results: compare
  always @(posedge clk) begin
    reading_t got, want;
    if (in_tvalid && in_tready) begin
      if (typed_flag.pop_front()) readings_due.push_back(typed_res.pop_front());
      else begin
        void'(typed_res.pop_front());
        readings_due.push_back(compensate(in_tdata[15:0], in_tdata[39:16]));
      end
      words_in++;
    end
    if (out_tvalid && out_tready) begin
      got = '{temp: out_tdata[15:0], press: out_tdata[33:16], err: out_tuser};
      words_out++;
      if (got.err) div_errors++;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word temp=%0d press=%0d err=%0b",
                                       $signed(got.temp), got.press, got.err);
      end else begin
        want = readings_due.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp temp=%0d press=%0d err=%0b, got temp=%0d press=%0d err=%0b",
                     $signed(want.temp), want.press, want.err,
                     $signed(got.temp), got.press, got.err);
        end
      end
    end
  end

  // result side backpressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if (!calm && rst_n && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  // present one word and hold it until taken, with an optional gap after
  task automatic send(input logic [15:0] ut, input logic [23:0] up,
                      input bit typed, input reading_t res);
    typed_flag.push_back(typed);
    typed_res.push_back(res);
    in_tvalid <= 1;
    in_tdata <= {up, ut};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // stop sending and let every word in flight come out
  task automatic drain();
    in_tvalid <= 0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // write all eight registers back to back
  task automatic program_cal(input cal_kind_e kind, input logic [1:0] oss);
    logic [31:0] v [8];
    case (kind)
      CAL_TYPICAL, CAL_NUDGED: begin
        v[REG_AC1] = 32'd408;
        v[REG_AC2] = 32'hFFB8;
        v[REG_AC3] = 32'hC7D1;
        v[REG_AC4] = 32'd32741;
        v[REG_AC5_AC6] = {16'd32757, 16'd23153};
        v[REG_B1_B2] = {16'd6190, 16'd4};
        v[REG_MC_MD] = {16'hDDF9, 16'd2868};
        if (kind == CAL_NUDGED)
          for (int i = 0; i < 7; i++) v[i] = v[i] ^ ($urandom() & 32'h00FF_00FF);
      end
      CAL_ALL_HI: for (int i = 0; i < 7; i++) v[i] = 32'h7FFF_7FFF;
      CAL_ALL_LO: for (int i = 0; i < 7; i++) v[i] = 32'h8000_8000;
      CAL_NO_B4: begin
        for (int i = 0; i < 7; i++) v[i] = $urandom();
        v[REG_AC4] = {16'($urandom_range(0, 65535)), 16'd0};
      end
      default: for (int i = 0; i < 7; i++) v[i] = $urandom();
    endcase
    v[REG_OSS] = {30'($urandom_range(0, 32'h3FFF_FFFF)), oss};
    cfg_valid <= 1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= i[2:0];
      cfg_data <= v[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cal_reg[i] = (i < 4) ? {16'd0, v[i][15:0]} : (i == REG_OSS) ? {30'd0, v[i][1:0]} : v[i];
    end
    cfg_valid <= 0;
  endtask

  localparam reading_t ZERO_DIV = '{temp: '0, press: '0, err: 1'b1};
  localparam reading_t NONE = '0;

  row_t directed[] = '{
    '{CAL_RESET,   2'd0, 16'h0000, 24'h000000, 1, ZERO_DIV},
    '{CAL_RESET,   2'd0, 16'hFFFF, 24'hFFFFFF, 1, ZERO_DIV},
    '{CAL_RESET,   2'd0, 16'h5A5A, 24'hA5A5A5, 1, ZERO_DIV},
    '{CAL_TYPICAL, 2'd0, 16'd27898, 24'd6103808, 0, NONE},
    '{CAL_TYPICAL, 2'd0, 16'h0000, 24'h000000, 0, NONE},
    '{CAL_TYPICAL, 2'd0, 16'hFFFF, 24'hFFFFFF, 0, NONE},
    '{CAL_TYPICAL, 2'd0, 16'hFFFF, 24'h000000, 0, NONE},
    '{CAL_TYPICAL, 2'd0, 16'h0000, 24'hFFFFFF, 0, NONE},
    '{CAL_TYPICAL, 2'd1, 16'd27898, 24'd6103808, 0, NONE},
    '{CAL_TYPICAL, 2'd2, 16'd27898, 24'hFFFFFF, 0, NONE},
    '{CAL_TYPICAL, 2'd3, 16'd27898, 24'd6103808, 0, NONE},
    '{CAL_TYPICAL, 2'd3, 16'hFFFF, 24'h000000, 0, NONE},
    '{CAL_ALL_HI,  2'd3, 16'h0000, 24'hFFFFFF, 0, NONE},
    '{CAL_ALL_HI,  2'd3, 16'hFFFF, 24'h000000, 0, NONE},
    '{CAL_ALL_LO,  2'd0, 16'h0000, 24'h000000, 0, NONE},
    '{CAL_ALL_LO,  2'd0, 16'hFFFF, 24'hFFFFFF, 0, NONE},
    '{CAL_NO_B4,   2'd1, 16'h1234, 24'h800000, 0, NONE},
    '{CAL_NO_B4,   2'd2, 16'hFFFF, 24'h7FFFFF, 0, NONE}
  };

  initial begin
    cal_kind_e   kind;
    logic [1:0]  oss;
    logic [15:0] ut;
    logic [23:0] up;
    for (int i = 0; i < 8; i++) cal_reg[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table; a new setup drains first
    kind = CAL_RESET;
    oss = 0;
    foreach (directed[i]) begin
      if (directed[i].kind != kind || directed[i].oss != oss) begin
        drain();
        kind = directed[i].kind;
        oss = directed[i].oss;
        program_cal(kind, oss);
      end
      send(directed[i].ut, directed[i].up, directed[i].typed, directed[i].res);
    end

    // random phases, mostly plausible calibrations and readings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0, 3, 5, 7: kind = CAL_NUDGED;
        1: kind = CAL_TYPICAL;
        2: kind = CAL_ALL_HI;
        4: kind = CAL_NO_B4;
        default: kind = CAL_RANDOM;
      endcase
      oss = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
      program_cal(kind, oss);
      if (ph == 7) calm = 1;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 3) != 0) begin
          ut = 16'(16'd27898 + $urandom_range(0, 8000) - 16'd4000);
          up = 24'(24'd6103808 + $urandom_range(0, 1_000_000) - 24'd500000);
        end else begin
          ut = 16'($urandom());
          up = 24'($urandom());
        end
        send(ut, up, 0, NONE);
      end
    end
    drain();

    $display("covered %0d words in, %0d out (%0d with divide error) over 8 random setups",
             words_in, words_out, div_errors);
    $display("all eight registers written, oversampling 0..3, %0d mismatches", mismatches);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d words outstanding", readings_due.size());
    $display("tb failed");
    $finish;
  end

endmodule
